// File: hw/rtl/bmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared constants, types and helpers of the bipartite matching unit.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int MAX_JOBS = 64;
    localparam int MAX_APPL = 64;
    localparam int ROW_W    = 64;                 // interest row width
    localparam int JOB_W    = $clog2(MAX_JOBS);   // job index
    localparam int APPL_W   = $clog2(MAX_APPL);   // applicant index
    localparam int CNT_W    = 7;                  // counts and job_count
    localparam int GRP_W    = 8;                  // bits per group in the bit search
    localparam int GRP_N    = ROW_W / GRP_W;
    localparam int GIDX_W   = $clog2(GRP_N);
    localparam int BIDX_W   = $clog2(GRP_W);

    typedef struct packed {
        logic [APPL_W-1:0] who;
        logic [JOB_W-1:0]  job;
    } frame_t;

    typedef struct packed {
        logic             start;
        logic [ROW_W-1:0] word;
    } ffs_req_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [JOB_W-1:0] idx;
    } ffs_res_t;

    typedef struct packed {
        logic             start;
        logic             last;
        logic [ROW_W-1:0] row;
    } core_cmd_t;

    typedef struct packed {
        logic             idle;
        logic             result_valid;
        logic [CNT_W-1:0] match_count;
    } core_stat_t;

    // Columns in use; anything above MAX_JOBS saturates to all ones.
    function automatic logic [ROW_W-1:0] jobs_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = (CNT_W'(i) < n) && (i < MAX_JOBS);
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/bipartite_max_matching_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_max_matching_unit
// Maximum bipartite matching by augmenting-path search, one applicant per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ beat carries one applicant's interest row (bit j = wants job j);
//   s_tlast marks the final row of the matrix. Bits at or above job_count are
//   dropped. On the final row one m_ beat returns the maximum matching size,
//   and the match table, row count and total are cleared for the next matrix.
//   Write job_count (cfg_wr_en/cfg_wr_data) only while the unit is idle; unchecked.
// Timing:
//   The search runs under one sequencer around a two-stage lowest-set-bit
//   finder and stores with separate read and write ports. Each job tried
//   costs a find plus owner and row reads, each backtrack a stack read and
//   a row read, each frame of the flipped path a stack read and an owner
//   write. s_tready is low during a search. Rows beyond the 64th of one
//   matrix are taken without a search and ignored; a final one still reports.
// Reset and stalls:
//   aresetn clears the matching state and sets job_count to 64. A result held
//   in the output register does not block new rows; only the next result waits
//   for m_tready.
// ----------------------------------------------------------------------------
module bipartite_max_matching_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,     // [63:0] interest_row
    input  logic                        s_tlast,     // last_row
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,     // [6:0] match_count, [7] zero
    input  logic                        cfg_wr_en,
    input  logic [bmm_pkg::CNT_W-1:0]   cfg_wr_data  // job_count
);
    import bmm_pkg::*;

    logic [CNT_W-1:0] job_count_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg;

    core_cmd_t  cmd;
    core_stat_t stat;
    logic       out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = stat.idle;
    assign cmd.start = s_tvalid && s_tready;
    assign cmd.last  = s_tlast;
    assign cmd.row   = s_tdata;

    bmm_search u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .col_mask (jobs_mask(job_count_reg)),
        .out_free (out_free),
        .stat     (stat)
    );

    assign m_tvalid_next = stat.result_valid || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_count_reg <= CNT_W'(MAX_JOBS);
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                job_count_reg <= cfg_wr_data;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
        if (stat.result_valid) begin
            m_tdata_reg <= {1'b0, stat.match_count};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result is only loaded into a free output slot
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.result_valid |-> out_free)
        else $error("result loaded over an untaken beat");

    // results come out of the sequencer, never while it is taking rows
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.result_valid |-> !s_tready)
        else $error("result produced while idle");

    // a row without the last mark never raises a result
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
        else $error("result after a non-final row");

endmodule

// File: hw/rtl/bmm_ffs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_ffs
// Two-stage lowest-set-bit finder: per-group search, then group select.
// ----------------------------------------------------------------------------
module bmm_ffs (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmm_pkg::ffs_req_t req,
    output bmm_pkg::ffs_res_t res
);
    import bmm_pkg::*;

    logic                          s1_valid_reg;
    logic [GRP_N-1:0]              s1_nz_reg;
    logic [GRP_N-1:0][BIDX_W-1:0]  s1_low_reg;
    logic [GRP_N-1:0]              s1_nz_next;
    logic [GRP_N-1:0][BIDX_W-1:0]  s1_low_next;

    ffs_res_t res_reg;
    ffs_res_t res_next;

    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            s1_nz_next[g]  = |req.word[g*GRP_W +: GRP_W];
            s1_low_next[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (req.word[g*GRP_W + b]) begin
                    s1_low_next[g] = BIDX_W'(b);
                end
            end
        end
    end

    always_comb begin
        res_next.valid = s1_valid_reg;
        res_next.found = |s1_nz_reg;
        res_next.idx   = '0;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (s1_nz_reg[g]) begin
                res_next.idx = {GIDX_W'(g), s1_low_reg[g]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            res_reg.valid <= 1'b0;
        end else begin
            s1_valid_reg  <= req.start;
            res_reg.valid <= res_next.valid;
        end
        s1_nz_reg     <= s1_nz_next;
        s1_low_reg    <= s1_low_next;
        res_reg.found <= res_next.found;
        res_reg.idx   <= res_next.idx;
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/bmm_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_search
// Augmenting-path sequencer: row store, owner table, explicit search stack.
// ----------------------------------------------------------------------------
module bmm_search (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bmm_pkg::core_cmd_t         cmd,
    input  logic [bmm_pkg::ROW_W-1:0]  col_mask,
    input  logic                       out_free,
    output bmm_pkg::core_stat_t        stat
);
    import bmm_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FIND    = 4'd1;
    localparam logic [3:0] S_WAIT    = 4'd2;
    localparam logic [3:0] S_OWN     = 4'd3;
    localparam logic [3:0] S_ROW     = 4'd4;
    localparam logic [3:0] S_POP     = 4'd5;
    localparam logic [3:0] S_FLIP_RD = 4'd6;
    localparam logic [3:0] S_FLIP_WR = 4'd7;
    localparam logic [3:0] S_END     = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0]    matched_reg, matched_next;
    logic [MAX_JOBS-1:0] owner_valid_reg, owner_valid_next;
    logic [ROW_W-1:0]    visited_reg, visited_next;
    logic [APPL_W-1:0]   cur_who_reg, cur_who_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [JOB_W-1:0]    top_reg, top_next;
    logic [JOB_W-1:0]    k_reg, k_next;
    logic                last_reg, last_next;

    // memories
    logic [ROW_W-1:0]  istore_mem [MAX_APPL];
    logic [APPL_W-1:0] owner_mem  [MAX_JOBS];
    frame_t            stack_mem  [MAX_JOBS];

    logic              istore_we, istore_re;
    logic [APPL_W-1:0] istore_waddr, istore_raddr;
    logic [ROW_W-1:0]  istore_wdata, istore_q;

    logic              owner_we, owner_re;
    logic [JOB_W-1:0]  owner_waddr, owner_raddr;
    logic [APPL_W-1:0] owner_wdata, owner_q;

    logic              stack_we, stack_re;
    logic [JOB_W-1:0]  stack_waddr, stack_raddr;
    frame_t            stack_wdata, stack_q;

    ffs_req_t ffs_req;
    ffs_res_t ffs_res;

    bmm_ffs u_ffs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ffs_req),
        .res     (ffs_res)
    );

    always_comb begin
        state_next       = state_reg;
        row_cnt_next     = row_cnt_reg;
        matched_next     = matched_reg;
        owner_valid_next = owner_valid_reg;
        visited_next     = visited_reg;
        cur_who_next     = cur_who_reg;
        cur_row_next     = cur_row_reg;
        top_next         = top_reg;
        k_next           = k_reg;
        last_next        = last_reg;

        istore_we    = 1'b0;
        istore_waddr = row_cnt_reg[APPL_W-1:0];
        istore_wdata = cmd.row & col_mask;
        istore_re    = 1'b0;
        istore_raddr = owner_q;

        owner_we     = 1'b0;
        owner_waddr  = stack_q.job;
        owner_wdata  = stack_q.who;
        owner_re     = 1'b0;
        owner_raddr  = ffs_res.idx;

        stack_we        = 1'b0;
        stack_waddr     = top_reg;
        stack_wdata.who = cur_who_reg;
        stack_wdata.job = ffs_res.idx;
        stack_re        = 1'b0;
        stack_raddr     = k_reg;

        ffs_req.start = 1'b0;
        ffs_req.word  = cur_row_reg & col_mask & ~visited_reg;

        stat.idle         = (state_reg == S_IDLE);
        stat.match_count  = matched_reg;
        stat.result_valid = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    last_next = cmd.last;
                    if (row_cnt_reg < CNT_W'(MAX_APPL)) begin
                        istore_we    = 1'b1;
                        cur_who_next = row_cnt_reg[APPL_W-1:0];
                        cur_row_next = cmd.row & col_mask;
                        top_next     = '0;
                        visited_next = '0;
                        row_cnt_next = row_cnt_reg + 1'b1;
                        state_next   = S_FIND;
                    end else if (cmd.last) begin
                        // problem already full: skip the search, still report
                        state_next = S_EMIT;
                    end
                end
            end
            S_FIND: begin
                ffs_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: begin
                if (ffs_res.valid) begin
                    if (ffs_res.found) begin
                        visited_next = visited_reg | (ROW_W'(1) << ffs_res.idx);
                        stack_we     = 1'b1;
                        if (!owner_valid_reg[ffs_res.idx]) begin
                            k_next     = '0;
                            state_next = S_FLIP_RD;
                        end else begin
                            owner_re   = 1'b1;
                            top_next   = top_reg + 1'b1;
                            state_next = S_OWN;
                        end
                    end else if (top_reg == '0) begin
                        state_next = S_END;
                    end else begin
                        stack_re    = 1'b1;
                        stack_raddr = top_reg - 1'b1;
                        top_next    = top_reg - 1'b1;
                        state_next  = S_POP;
                    end
                end
            end
            S_OWN: begin
                cur_who_next = owner_q;
                istore_re    = 1'b1;
                istore_raddr = owner_q;
                state_next   = S_ROW;
            end
            S_POP: begin
                cur_who_next = stack_q.who;
                istore_re    = 1'b1;
                istore_raddr = stack_q.who;
                state_next   = S_ROW;
            end
            S_ROW: begin
                cur_row_next = istore_q;
                state_next   = S_FIND;
            end
            S_FLIP_RD: begin
                stack_re   = 1'b1;
                state_next = S_FLIP_WR;
            end
            S_FLIP_WR: begin
                owner_we = 1'b1;
                owner_valid_next[stack_q.job] = 1'b1;
                if (k_reg == top_reg) begin
                    matched_next = matched_reg + 1'b1;
                    state_next   = S_END;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_FLIP_RD;
                end
            end
            S_END: begin
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    stat.result_valid = 1'b1;
                    owner_valid_next  = '0;
                    row_cnt_next      = '0;
                    matched_next      = '0;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            row_cnt_reg     <= '0;
            matched_reg     <= '0;
            owner_valid_reg <= '0;
            visited_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            row_cnt_reg     <= row_cnt_next;
            matched_reg     <= matched_next;
            owner_valid_reg <= owner_valid_next;
            visited_reg     <= visited_next;
        end
        cur_who_reg <= cur_who_next;
        cur_row_reg <= cur_row_next;
        top_reg     <= top_next;
        k_reg       <= k_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (istore_we) begin
            istore_mem[istore_waddr] <= istore_wdata;
        end
        if (istore_re) begin
            istore_q <= istore_mem[istore_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner_mem[owner_waddr] <= owner_wdata;
        end
        if (owner_re) begin
            owner_q <= owner_mem[owner_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            stack_q <= stack_mem[stack_raddr];
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bipartite matching unit. Interest matrices are
// streamed in row by row; a scoreboard runs its own augmenting-path matcher
// on each accepted row up to the 64th of a matrix and checks each returned
// matching size in order. Covers job_count extremes, masked columns,
// matrices beyond 64 rows and random back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb;
    import bmm_pkg::*;

    localparam int PHASE_ROWS  = 45;      // minimum rows per job_count setting
    localparam int CFG_GAP     = 16;      // settle cycles before a register write
    localparam int TAIL_CYCLES = 800;     // worst single-row search plus margin
    localparam int DRAIN_LIMIT = 200000;

    typedef logic [ROW_W-1:0] row_t;

    class matching_scoreboard;
        logic [CNT_W-1:0]  job_count;
        row_t              rows [MAX_APPL];
        logic [CNT_W-1:0]  owner [MAX_JOBS];
        logic [MAX_JOBS-1:0] owned;
        logic [MAX_JOBS-1:0] visited;
        int                row_cnt;
        int                total;
        logic [CNT_W-1:0]  sizes_q [$];
        int                errors;
        int                checked;

        function new();
            job_count = CNT_W'(64);
            errors    = 0;
            checked   = 0;
            clear_matrix();
        endfunction

        function void clear_matrix();
            owned   = '0;
            visited = '0;
            row_cnt = 0;
            total   = 0;
            foreach (owner[i]) owner[i] = '0;
        endfunction

        function row_t col_mask();
            int n;
            n = (job_count > MAX_JOBS) ? MAX_JOBS : job_count;
            if (n >= ROW_W) return '1;
            return (row_t'(1) << n) - row_t'(1);
        endfunction

        // Depth-first search, lowest job first; the path is flipped on unwind.
        function bit seek_job(int who);
            for (int j = 0; j < MAX_JOBS; j++) begin
                if (rows[who][j] && !visited[j]) begin
                    visited[j] = 1'b1;
                    if (!owned[j] || seek_job(owner[j])) begin
                        owner[j] = CNT_W'(who);
                        owned[j] = 1'b1;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_row(row_t row, logic last);
            if (row_cnt < MAX_APPL) begin
                rows[row_cnt] = row & col_mask();
                visited = '0;
                if (seek_job(row_cnt)) total++;
                row_cnt++;
            end
            if (last) begin
                sizes_q.push_back(CNT_W'(total));
                clear_matrix();
            end
        endfunction

        function void check_size(logic [7:0] data);
            logic [CNT_W-1:0] want;
            if (sizes_q.size() == 0) begin
                $error("match_count: no result expected, actual %0d", data[CNT_W-1:0]);
                errors++;
                return;
            end
            want = sizes_q.pop_front();
            checked++;
            if (data[CNT_W-1:0] !== want) begin
                $error("match_count mismatch: expected %0d, actual %0d",
                       want, data[CNT_W-1:0]);
                errors++;
            end
        endfunction

        function int pending();
            return sizes_q.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [63:0]        s_tdata;     // [63:0] interest_row
    logic               s_tlast;     // last_row
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;     // [6:0] match_count, [7] zero
    logic               cfg_wr_en;
    logic [CNT_W-1:0]   cfg_wr_data; // job_count

    matching_scoreboard sb;
    int src_idle_pct;
    int snk_idle_pct;
    int rows_sent;
    int matrices_sent;
    int settings_used;

    bipartite_max_matching_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous cap: far above the slowest legal run.
    initial begin
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_size(m_tdata);
    end

    task automatic send_row(input row_t row, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_row(row, last);
        rows_sent++;
        if (last) matrices_sent++;
    endtask

    task automatic wait_idle(input int settle);
        int n;
        n = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_jobs(input logic [CNT_W-1:0] n);
        wait_idle(CFG_GAP);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.job_count = n;
        settings_used++;
    endtask

    // Rows mostly confined to a column span near the row count so that
    // applicants compete and searches run deep.
    function automatic row_t pick_row(int nrows);
        int   sel;
        int   eff;
        int   span;
        row_t span_mask;
        row_t r;
        sel = $urandom_range(99);
        eff = (sb.job_count > MAX_JOBS) ? MAX_JOBS : sb.job_count;
        if (sel < 5)  return '0;
        if (sel < 10) return '1;
        if (sel < 16 || eff == 0) return {$urandom, $urandom};
        if (sel < 22) return row_t'(1) << $urandom_range(ROW_W - 1);
        span = nrows + $urandom_range(2);
        if (span > eff) span = eff;
        span_mask = (span >= ROW_W) ? '1 : ((row_t'(1) << span) - row_t'(1));
        case ($urandom_range(2))
            0: r = {$urandom, $urandom} & {$urandom, $urandom};
            1: r = row_t'(1) << $urandom_range(span - 1);
            default: r = {$urandom, $urandom};
        endcase
        r = r & span_mask;
        if ($urandom_range(99) < 30) r = r | ({$urandom, $urandom} & ~sb.col_mask());
        return r;
    endfunction

    task automatic send_matrix(input int nrows);
        for (int i = 0; i < nrows; i++) begin
            send_row(pick_row(nrows), i == nrows - 1);
        end
    endtask

    function automatic int pick_rows();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)  return $urandom_range(65, 70);
        if (sel < 15) return $urandom_range(20, 64);
        return $urandom_range(1, 10);
    endfunction

    logic [CNT_W-1:0] settings [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd40, 7'd65, 7'd16};
    int phase_start;

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        src_idle_pct = 6;
        snk_idle_pct = 47;
        rows_sent     = 0;
        matrices_sent = 0;
        settings_used = 1;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset job_count of 64 first.
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        // Row 1 forces row 0 to move; row 2 then fails; top column free.
        send_row(64'h3, 1'b0);
        send_row(64'h1, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        // Columns at or above job_count are dropped.
        write_jobs(7'd4);
        send_row(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
        send_row(64'hF, 1'b0);
        send_row(64'h10, 1'b1);
        // No columns at all.
        write_jobs(7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // Above the maximum saturates to every column.
        write_jobs(7'd127);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        write_jobs(7'd1);
        send_row(64'h1, 1'b0);
        send_row(64'h3, 1'b0);
        send_row('1, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin src_idle_pct = 6;  snk_idle_pct = 47; end
                1: begin src_idle_pct = 47; snk_idle_pct = 6;  end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int s = 0; s < 9; s++) begin
                write_jobs((s < 8) ? settings[s] : CNT_W'($urandom_range(1, 64)));
                phase_start = rows_sent;
                // One matrix past the row limit per mode.
                if (s == 0) send_matrix($urandom_range(66, 70));
                while (rows_sent - phase_start < PHASE_ROWS) send_matrix(pick_rows());
            end
        end

        wait_idle(TAIL_CYCLES);
        if (sb.pending() != 0) begin
            $error("match_count: %0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Run covered %0d rows in %0d matrices under %0d job_count settings",
                 rows_sent, matrices_sent, settings_used);
        $display("Matching sizes checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ffs.sv
hw/rtl/bmm_search.sv
hw/rtl/bipartite_max_matching_unit.sv
test/tb.sv
